// File: src/vln_pkg.sv
// Shared types and constants of the vector L2 normaliser.
`timescale 1ns / 1ps
`default_nettype none
package vln_pkg;

  // Default vector length that the element store holds.
  localparam int MAX_DIM_DEF = 64;

  // Field widths of one input item and one result item.
  localparam int ELEM_W = 16;
  // Sum of squares width, and the radicand register, which is padded to an even width.
  localparam int SUM_W  = 37;
  localparam int RAD_W  = 38;
  // Integer square root of the sum fits in this many bits.
  localparam int ROOT_W = 19;
  // Partial remainder of the root extraction.
  localparam int REM_W  = 20;
  // Width of the shared compare and subtract unit.
  localparam int CS_W   = 22;

  // One root bit per step, and one quotient bit per step.
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int DIV_STEPS  = 15;
  localparam int ITER_W     = 5;

  // Unity in Q1.14, which is also the saturation bound of a result.
  localparam logic [DIV_STEPS-1:0] ONE_Q14 = 15'd16384;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     last_element;
  } vln_in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] unit_element;
    logic                     last_result;
  } vln_out_t;

endpackage
`default_nettype wire

// File: src/vln_store.sv
// Element store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module vln_store #(
  parameter int DEPTH = vln_pkg::MAX_DIM_DEF,
  parameter int AW    = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [vln_pkg::ELEM_W-1:0]  wr_data_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output logic      [vln_pkg::ELEM_W-1:0]  rd_data_o
);
  import vln_pkg::*;

  logic [ELEM_W-1:0] mem_q [DEPTH];

  // Write the arriving element at the fill position.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read of the element being normalised.
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule
`default_nettype wire

// File: src/vln_cmpsub.sv
// Shared compare and subtract unit used by the root extraction and the division.
`timescale 1ns / 1ps
`default_nettype none
module vln_cmpsub (
  input  wire logic [vln_pkg::CS_W-1:0] a_i,
  input  wire logic [vln_pkg::CS_W-1:0] b_i,
  output logic                          ge_o,
  output logic      [vln_pkg::CS_W-1:0] diff_o
);
  import vln_pkg::*;

  logic [CS_W:0] wide_diff;

  // One subtraction gives both the difference and the borrow.
  always_comb begin
    wide_diff = {1'b0, a_i} - {1'b0, b_i};
    ge_o      = ~wide_diff[CS_W];
    diff_o    = wide_diff[CS_W-1:0];
  end

endmodule
`default_nettype wire

// File: src/vector_l2_normalizer.sv
// Top level of the vector L2 normaliser: sequencer, sum of squares and output register.
// An item without the last mark is taken while the block gathers elements and gives no result.
// After the last item the square root is extracted, then each stored element passes
// through read, set-up, 15 division steps and output, using the shared compare and
// subtract unit; the output step waits while the output is stalled.
// Reset clears the sequencer, the sum, the fill count and the output register;
// the element store is not cleared, as only entries of the current vector are read.
`timescale 1ns / 1ps
`default_nettype none
module vector_l2_normalizer #(
  parameter int MAX_DIM = vln_pkg::MAX_DIM_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire vln_pkg::vln_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output vln_pkg::vln_out_t      out_data_o
);
  import vln_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SQRT,
    S_READ,
    S_DINIT,
    S_DIV,
    S_PUT
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [RAD_W-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  logic [DIV_STEPS-1:0] dvd_q, dvd_d;
  logic [DIV_STEPS-1:0] quo_q, quo_d;
  logic                 neg_q, neg_d;
  logic [ITER_W-1:0]    iter_q, iter_d;
  logic                 out_valid_q, out_valid_d;
  vln_out_t             out_data_q, out_data_d;

  logic                 accept;
  logic                 room;
  logic [ELEM_W-1:0]    mag_in;
  logic [2*ELEM_W-1:0]  square;
  logic [SUM_W-1:0]     sum_next;
  logic [ELEM_W-1:0]    rd_data;
  logic [ELEM_W-1:0]    mag_rd;
  logic [CS_W-1:0]      cs_a, cs_b, cs_diff;
  logic                 cs_ge;
  logic                 is_last_out;
  logic [DIV_STEPS-1:0] quo_sat;
  logic [ELEM_W-1:0]    quo_ext;

  // Input side: an item is taken only while the block gathers elements.
  assign in_stall_o = (state_q != S_LOAD);
  assign accept     = in_valid_i && (state_q == S_LOAD);
  assign room       = (count_q < CW'(MAX_DIM));

  // Magnitude and square of the arriving element.
  always_comb begin
    mag_in   = in_data_i.element[ELEM_W-1] ? (~in_data_i.element + 1'b1) : in_data_i.element;
    square   = mag_in * mag_in;
    sum_next = sum_q + SUM_W'(square);
  end

  vln_store #(
    .DEPTH (MAX_DIM),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept && room),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (in_data_i.element),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Operand selection for the shared unit: a root trial or a division step.
  always_comb begin
    if (state_q == S_SQRT) begin
      cs_a = {rem_q, rad_q[RAD_W-1 -: 2]};
      cs_b = {1'b0, root_q, 2'b01};
    end else begin
      cs_a = {2'b00, rem_q[ROOT_W-1:0], dvd_q[DIV_STEPS-1]};
      cs_b = {3'b000, root_q};
    end
  end

  vln_cmpsub u_cmpsub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .ge_o   (cs_ge),
    .diff_o (cs_diff)
  );

  // Result formatting: saturate, apply the sign, force zero for a zero norm.
  always_comb begin
    mag_rd      = rd_data[ELEM_W-1] ? (~rd_data + 1'b1) : rd_data;
    is_last_out = ((idx_q + CW'(1)) == count_q);
    if (root_q == '0) begin
      quo_sat = '0;
    end else if (quo_q > ONE_Q14) begin
      quo_sat = ONE_Q14;
    end else begin
      quo_sat = quo_q;
    end
    quo_ext = {1'b0, quo_sat};
    out_data_d.unit_element = neg_q ? (~quo_ext + 1'b1) : quo_ext;
    out_data_d.last_result  = is_last_out;
  end

  // Sequencer: gather, extract the root, then divide each stored element.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    neg_d       = neg_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (room) begin
            count_d = count_q + CW'(1);
            sum_d   = sum_next;
          end
          if (in_data_i.last_element) begin
            rad_d   = {1'b0, (room ? sum_next : sum_q)};
            sum_d   = '0;
            rem_d   = '0;
            root_d  = '0;
            iter_d  = '0;
            state_d = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        rad_d  = rad_q << 2;
        rem_d  = cs_ge ? cs_diff[REM_W-1:0] : cs_a[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], cs_ge};
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(SQRT_STEPS - 1)) begin
          idx_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_DINIT;
      end
      S_DINIT: begin
        rem_d   = {5'b00000, mag_rd[ELEM_W-1:1]};
        dvd_d   = {mag_rd[0], 14'b0};
        neg_d   = rd_data[ELEM_W-1];
        quo_d   = '0;
        iter_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = {1'b0, (cs_ge ? cs_diff[ROOT_W-1:0] : cs_a[ROOT_W-1:0])};
        quo_d  = {quo_q[DIV_STEPS-2:0], cs_ge};
        dvd_d  = dvd_q << 1;
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (is_last_out) begin
            count_d = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // State, working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      dvd_q       <= '0;
      quo_q       <= '0;
      neg_q       <= 1'b0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      rad_q       <= rad_d;
      rem_q       <= rem_d;
      root_q      <= root_d;
      dvd_q       <= dvd_d;
      quo_q       <= quo_d;
      neg_q       <= neg_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
      if ((state_q == S_PUT) && (!out_valid_q || !out_stall_i)) begin
        out_data_q <= out_data_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // The fill count never passes the store depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_DIM))
    else $error("Element count exceeds the store depth.");

  // The partial remainder of a division stays below the root.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && root_q != '0) |-> (rem_q < {1'b0, root_q}))
    else $error("Division remainder is not below the root.");

  // A quotient never exceeds unity, since the root bounds every element.
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && root_q != '0) |-> (quo_q <= ONE_Q14))
    else $error("Quotient exceeds unity.");

  // Each output handed over in the output state is valid in the next cycle.
  a_put_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUT && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("Result was not loaded into the output register.");
`endif

endmodule
`default_nettype wire
